// File: hdl/min_queue_two_stack_macros.svh
// Assertion macros for the min queue block.
// Each macro expects signals clk and arst_n in the scope that uses it.
`ifndef MIN_QUEUE_TWO_STACK_MACROS_SVH
`define MIN_QUEUE_TWO_STACK_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MQTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MQTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/mqts_pkg.sv
// Package for the min queue block: sizes, transaction structs, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package mqts_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int OUT_WIDTH  = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [PTR_W-1:0]             ptr_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef struct packed {
		logic                        mode;
		logic signed [OUT_WIDTH-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] min_value;
		logic                        was_empty;
		logic                        push_dropped;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_XFER,
		ST_RELOAD,
		ST_DONE
	} state_t;

endpackage

// File: hdl/min_queue_two_stack.sv
// Min queue built from two stacks with running minimums, top level.
// Depends on mqts_pkg and min_queue_two_stack_macros.svh.
`timescale 1ns / 1ps
`include "min_queue_two_stack_macros.svh"

// Channel  | Direction | Handshake                    | Payload
// item     | in        | item_valid / item_stall      | mqts_pkg::item_t   (mode, value)
// result   | out       | result_valid / result_stall  | mqts_pkg::result_t (one per item)
//
// Steps: a push is accepted, executed and reported; a pop with a
// non-empty front stack does the same, with a reload of the front top
// from the front memory when entries remain below it. A pop that finds the
// front stack empty first moves the back stack over at one entry a cycle;
// the single compare unit and the one read port per stack memory set this rate.
// Reset clears both counts and the sequencer; stack memories are not cleared.
// The result register decouples the sides: a new item is taken while the
// previous result is still stalled; a finished item waits in its last state.
module min_queue_two_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mqts_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output mqts_pkg::result_t   result
);

	// Sequencer and item under work
	mqts_pkg::state_t  state_q, state_d;
	mqts_pkg::item_t   item_q;
	mqts_pkg::result_t res_q;
	mqts_pkg::result_t result_q;
	logic              result_valid_q;

	// Stack counts and cached top-of-stack minimums. The back stack minimum
	// only ever needs its top, so only back values are stored in memory.
	mqts_pkg::cnt_t  back_count_q;
	mqts_pkg::cnt_t  front_count_q;
	mqts_pkg::data_t back_top_q;
	mqts_pkg::data_t front_top_q;

	// Memories with registered read data
	mqts_pkg::data_t back_mem [mqts_pkg::DEPTH];
	mqts_pkg::data_t front_mem [mqts_pkg::DEPTH];
	mqts_pkg::data_t back_rd_q;
	mqts_pkg::data_t front_rd_q;

	// Control decoded from the state
	typedef struct packed {
		logic back_we;
		logic back_re;
		logic back_inc;
		logic back_dec;
		logic back_top_ld;
		logic front_we;
		logic front_re;
		logic front_inc;
		logic front_dec;
		logic front_top_ld;
		logic front_top_rd;
		logic res_set;
	} ctrl_t;

	ctrl_t             ctrl;
	mqts_pkg::result_t res_d;
	mqts_pkg::data_t   min_d;

	// Shared compare unit
	mqts_pkg::data_t cmp_a, cmp_b;
	logic            cmp_lt;

	logic                   item_fire;
	logic                   back_nz, front_nz, front_gt1;
	logic [mqts_pkg::CNT_W:0] total;
	logic                   full;
	mqts_pkg::cnt_t         back_top_idx, front_next_idx;
	mqts_pkg::data_t        push_value;

	assign item_stall = (state_q != mqts_pkg::ST_IDLE);
	assign item_fire  = item_valid && !item_stall;

	assign back_nz   = (back_count_q != '0);
	assign front_nz  = (front_count_q != '0);
	assign front_gt1 = (front_count_q > mqts_pkg::CNT_W'(1));
	assign total     = {1'b0, back_count_q} + {1'b0, front_count_q};
	assign full      = (total >= (mqts_pkg::CNT_W + 1)'(mqts_pkg::DEPTH));

	assign back_top_idx   = back_count_q - mqts_pkg::CNT_W'(1);
	assign front_next_idx = front_count_q - mqts_pkg::CNT_W'(2);
	assign push_value     = mqts_pkg::DATA_WIDTH'(item_q.value);

	// Operand select for the compare unit
	always_comb begin
		cmp_a = push_value;
		cmp_b = back_top_q;
		if (state_q == mqts_pkg::ST_XFER) begin
			cmp_a = back_rd_q;
			cmp_b = front_top_q;
		end else if (item_q.mode == mqts_pkg::MODE_POP) begin
			cmp_a = back_top_q;
			cmp_b = front_top_q;
		end
	end

	assign cmp_lt = (cmp_a < cmp_b);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mqts_pkg::ST_IDLE: begin
				if (item_valid) state_d = mqts_pkg::ST_EXEC;
			end
			mqts_pkg::ST_EXEC: begin
				if (item_q.mode == mqts_pkg::MODE_PUSH) state_d = mqts_pkg::ST_DONE;
				else if (!front_nz) state_d = back_nz ? mqts_pkg::ST_XFER : mqts_pkg::ST_DONE;
				else state_d = front_gt1 ? mqts_pkg::ST_RELOAD : mqts_pkg::ST_DONE;
			end
			mqts_pkg::ST_XFER: begin
				if (!back_nz) state_d = mqts_pkg::ST_EXEC;
			end
			mqts_pkg::ST_RELOAD: begin
				state_d = mqts_pkg::ST_DONE;
			end
			mqts_pkg::ST_DONE: begin
				if (!result_valid_q || !result_stall) state_d = mqts_pkg::ST_IDLE;
			end
			default: state_d = mqts_pkg::ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		ctrl  = '0;
		res_d = '0;
		min_d = push_value;
		unique case (state_q)
			mqts_pkg::ST_EXEC: begin
				if (item_q.mode == mqts_pkg::MODE_PUSH) begin
					ctrl.res_set = 1'b1;
					if (full) begin
						res_d.push_dropped = 1'b1;
					end else begin
						min_d            = (back_nz && !cmp_lt) ? back_top_q : push_value;
						ctrl.back_we     = 1'b1;
						ctrl.back_inc    = 1'b1;
						ctrl.back_top_ld = 1'b1;
					end
				end else if (!front_nz) begin
					if (back_nz) begin
						ctrl.back_re  = 1'b1;
						ctrl.back_dec = 1'b1;
					end else begin
						ctrl.res_set    = 1'b1;
						res_d.was_empty = 1'b1;
					end
				end else begin
					min_d           = (back_nz && cmp_lt) ? back_top_q : front_top_q;
					ctrl.res_set    = 1'b1;
					res_d.min_value = mqts_pkg::OUT_WIDTH'(min_d);
					ctrl.front_dec  = 1'b1;
					ctrl.front_re   = front_gt1;
				end
			end
			mqts_pkg::ST_XFER: begin
				// Fresh running minimum as each value lands on the front stack
				min_d             = (front_nz && !cmp_lt) ? front_top_q : back_rd_q;
				ctrl.front_we     = 1'b1;
				ctrl.front_inc    = 1'b1;
				ctrl.front_top_ld = 1'b1;
				ctrl.back_re      = back_nz;
				ctrl.back_dec     = back_nz;
			end
			mqts_pkg::ST_RELOAD: begin
				ctrl.front_top_rd = 1'b1;
			end
			mqts_pkg::ST_IDLE: begin
			end
			mqts_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mqts_pkg::ST_IDLE;
			back_count_q   <= '0;
			front_count_q  <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.back_inc) back_count_q <= back_count_q + mqts_pkg::CNT_W'(1);
			else if (ctrl.back_dec) back_count_q <= back_count_q - mqts_pkg::CNT_W'(1);
			if (ctrl.front_inc) front_count_q <= front_count_q + mqts_pkg::CNT_W'(1);
			else if (ctrl.front_dec) front_count_q <= front_count_q - mqts_pkg::CNT_W'(1);
			if (state_q == mqts_pkg::ST_DONE && (!result_valid_q || !result_stall))
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_fire) item_q <= item;
		if (ctrl.res_set) res_q <= res_d;
		if (ctrl.back_top_ld) back_top_q <= min_d;
		if (ctrl.front_top_ld) front_top_q <= min_d;
		else if (ctrl.front_top_rd) front_top_q <= front_rd_q;
		if (state_q == mqts_pkg::ST_DONE && (!result_valid_q || !result_stall))
			result_q <= res_q;
	end

	// Back stack memory
	always_ff @(posedge clk) begin
		if (ctrl.back_we) back_mem[back_count_q[mqts_pkg::PTR_W-1:0]] <= push_value;
		if (ctrl.back_re) back_rd_q <= back_mem[back_top_idx[mqts_pkg::PTR_W-1:0]];
	end

	// Front stack minimum memory
	always_ff @(posedge clk) begin
		if (ctrl.front_we) front_mem[front_count_q[mqts_pkg::PTR_W-1:0]] <= min_d;
		if (ctrl.front_re) front_rd_q <= front_mem[front_next_idx[mqts_pkg::PTR_W-1:0]];
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MQTS_ASSERT_IMPL(a_occupancy, 1'b1, total <= (mqts_pkg::CNT_W + 1)'(mqts_pkg::DEPTH), "queue occupancy above depth")
	`MQTS_ASSERT_NEXT(a_busy_after_accept, item_fire, state_q == mqts_pkg::ST_EXEC, "accepted transaction not executed")
	`MQTS_ASSERT_IMPL(a_xfer_is_pop, state_q == mqts_pkg::ST_XFER, item_q.mode == mqts_pkg::MODE_POP && front_count_q < mqts_pkg::CNT_W'(mqts_pkg::DEPTH), "stack transfer outside a pop")
	`MQTS_ASSERT_IMPL(a_result_from_done, $rose(result_valid_q), $past(state_q) == mqts_pkg::ST_DONE, "result raised outside completion")

endmodule

// File: sim/tb_min_queue_two_stack.sv
// Self-checking testbench for min_queue_two_stack: pushes and pops signed values and checks
// each reported minimum against a two-stack queue model kept here.
// Depends on mqts_pkg and the min_queue_two_stack RTL.
`timescale 1ns / 1ps

module tb_min_queue_two_stack;

	// Hard stop.
	localparam int LIMIT_CYCLES = 600000;
	// Quiet cycles after the last result, to catch any stray extra transaction.
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_ITEMS = 400;

	localparam mqts_pkg::data_t VAL_MAX = {1'b0, {(mqts_pkg::DATA_WIDTH-1){1'b1}}};
	localparam mqts_pkg::data_t VAL_MIN = {1'b1, {(mqts_pkg::DATA_WIDTH-1){1'b0}}};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	mqts_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	mqts_pkg::result_t result;

	min_queue_two_stack dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Queue model: two stacks, each entry carrying the running minimum
	// of everything beneath it on the same stack. Only the back values
	// are ever read again, so the front stack keeps minimums only.
	// ------------------------------------------------------------------
	mqts_pkg::data_t back_val  [mqts_pkg::DEPTH];
	mqts_pkg::data_t back_min  [mqts_pkg::DEPTH];
	mqts_pkg::data_t front_min [mqts_pkg::DEPTH];
	int    back_n  = 0;
	int    front_n = 0;

	mqts_pkg::result_t awaited_results [$];

	int errors      = 0;
	int n_checked   = 0;
	int n_push_ok   = 0;
	int n_dropped   = 0;
	int n_pop_ok    = 0;
	int n_pop_empty = 0;
	int cycles      = 0;

	// Updates the model for one accepted transaction and returns what the
	// block should report for it.
	function automatic mqts_pkg::result_t next_queue_result(mqts_pkg::item_t it);
		mqts_pkg::result_t r;
		mqts_pkg::data_t   v;
		mqts_pkg::data_t   m;
		r = '0;
		v = it.value[mqts_pkg::DATA_WIDTH-1:0];
		if (it.mode == mqts_pkg::MODE_PUSH) begin
			if (back_n + front_n >= mqts_pkg::DEPTH) begin
				r.push_dropped = 1'b1;
				return r;
			end
			m = v;
			if (back_n > 0 && back_min[back_n-1] < m)
				m = back_min[back_n-1];
			back_val[back_n] = v;
			back_min[back_n] = m;
			back_n++;
			return r;
		end
		// Pop: refill the front stack first if it has run dry.
		if (front_n == 0) begin
			while (back_n > 0 && front_n < mqts_pkg::DEPTH) begin
				back_n--;
				v = back_val[back_n];
				m = v;
				if (front_n > 0 && front_min[front_n-1] < m)
					m = front_min[front_n-1];
				front_min[front_n] = m;
				front_n++;
			end
		end
		if (front_n == 0) begin
			r.was_empty = 1'b1;
			return r;
		end
		m = front_min[front_n-1];
		if (back_n > 0 && back_min[back_n-1] < m)
			m = back_min[back_n-1];
		r.min_value = m;
		front_n--;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: checks the result transaction first, then feeds any accepted
	// item transaction to the model, so ordering within the edge is fixed.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		mqts_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_checked++;
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual min=%0d empty=%0b drop=%0b",
						$time, result.min_value, result.was_empty, result.push_dropped);
				end else begin
					want = awaited_results.pop_front();
					if (result.min_value !== want.min_value) begin
						errors++;
						$display("%0t: min_value expected %0d actual %0d",
							$time, want.min_value, result.min_value);
					end
					if (result.was_empty !== want.was_empty) begin
						errors++;
						$display("%0t: was_empty expected %0b actual %0b",
							$time, want.was_empty, result.was_empty);
					end
					if (result.push_dropped !== want.push_dropped) begin
						errors++;
						$display("%0t: push_dropped expected %0b actual %0b",
							$time, want.push_dropped, result.push_dropped);
					end
				end
			end
			if (item_valid && !item_stall) begin
				want = next_queue_result(item);
				awaited_results.insert(awaited_results.size(), want);
				if (item.mode == mqts_pkg::MODE_PUSH) begin
					if (want.push_dropped) n_dropped++;
					else n_push_ok++;
				end else begin
					if (want.was_empty) n_pop_empty++;
					else n_pop_ok++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver back-pressure: segments of random length, each with its own
	// flavour - no stall, light, heavy, or a regular on/off wave.
	// ------------------------------------------------------------------
	int stall_kind = 0;
	int stall_left = 0;
	int wave_on    = 1;
	int wave_off   = 1;
	int wave_pos   = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 3);
			stall_left = $urandom_range(16, 200);
			wave_on    = $urandom_range(1, 12);
			wave_off   = $urandom_range(1, 6);
			wave_pos   = 0;
		end
		stall_left--;
		case (stall_kind)
			0: begin
				result_stall <= 1'b0;
			end
			1: begin
				result_stall <= ($urandom_range(0, 99) < 25);
			end
			2: begin
				result_stall <= ($urandom_range(0, 99) < 75);
			end
			default: begin
				result_stall <= (wave_pos < wave_on);
				wave_pos = (wave_pos + 1) % (wave_on + wave_off);
			end
		endcase
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, awaited_results.size());
			$display("tb_min_queue_two_stack NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender. Called at a rising edge; returns at a rising edge. Items go
	// out in bursts; after a burst valid may drop for a random gap.
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_item(input logic op, input mqts_pkg::data_t v);
		mqts_pkg::item_t it;
		int              gap;
		it.mode  = op;
		it.value = v;
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait for every outstanding result to come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// Mix of fully random words, small values (plenty of ties) and extremes.
	function automatic mqts_pkg::data_t pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return mqts_pkg::data_t'($urandom);
		if (sel < 8)
			return mqts_pkg::data_t'($signed($urandom_range(0, 16)) - 8);
		case ($urandom_range(0, 5))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return mqts_pkg::data_t'(0);
			3: return mqts_pkg::data_t'(-1);
			4: return VAL_MIN + 1;
			default: return VAL_MAX - 1;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Pop straight after reset: nothing queued, value field ignored.
	task automatic test_empty_pop();
		send_item(mqts_pkg::MODE_POP, mqts_pkg::data_t'(-1));
		send_item(mqts_pkg::MODE_POP, mqts_pkg::data_t'(0));
		wait_drained();
	endtask

	// Extreme values, zero, ties, and the minimum sitting on either stack.
	task automatic test_extremes();
		send_item(mqts_pkg::MODE_PUSH, VAL_MAX);
		send_item(mqts_pkg::MODE_PUSH, mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_PUSH, VAL_MIN);
		send_item(mqts_pkg::MODE_PUSH, mqts_pkg::data_t'(-1));
		send_item(mqts_pkg::MODE_PUSH, mqts_pkg::data_t'(1));
		send_item(mqts_pkg::MODE_POP,  VAL_MAX);   // moves all five to the front stack
		send_item(mqts_pkg::MODE_PUSH, VAL_MIN);   // equal minimum now on the back stack
		send_item(mqts_pkg::MODE_PUSH, VAL_MAX);
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0)); // front minimum VAL_MIN leaves
		send_item(mqts_pkg::MODE_PUSH, VAL_MIN + 1);
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0)); // front dry: back moves again
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0));
		send_item(mqts_pkg::MODE_POP,  mqts_pkg::data_t'(0)); // empty again
		wait_drained();
	endtask

	// Random traffic in phases with different push/pop balance, so the queue
	// grows, shrinks and runs empty over and over.
	task automatic test_random(input int n_items);
		int phase_left;
		int push_pct;
		phase_left = 0;
		push_pct   = 50;
		for (int i = 0; i < n_items; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				case ($urandom_range(0, 3))
					0: push_pct = 80;
					1: push_pct = 30;
					2: push_pct = 60;
					default: push_pct = 50;
				endcase
			end
			phase_left--;
			if ($urandom_range(0, 99) < push_pct)
				send_item(mqts_pkg::MODE_PUSH, pick_value());
			else
				send_item(mqts_pkg::MODE_POP, pick_value());
		end
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pop();
		test_extremes();
		test_random(RANDOM_ITEMS);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d pushes stored, %0d dropped on a full queue,",
			n_checked, n_push_ok, n_dropped);
		$display("%0d pops with a minimum, %0d pops on an empty queue.",
			n_pop_ok, n_pop_empty);
		if (errors == 0 && awaited_results.size() == 0) begin
			$display("tb_min_queue_two_stack OK");
		end else begin
			$display("tb_min_queue_two_stack NOT OK");
		end
		$finish;
	end

endmodule
